### hdl/drc_pkg.sv
// Package with the shared types, constants and helpers of the dirty rectangle coalescer.
package drc_pkg;

  localparam int MaxEntries = 16;
  localparam int CountW = $clog2(MaxEntries + 1);
  localparam int IdxW = (MaxEntries > 1) ? $clog2(MaxEntries) : 1;

  localparam logic [1:0] ActAdd = 2'd0;
  localparam logic [1:0] ActClear = 2'd1;
  localparam logic [1:0] ActEmit = 2'd2;

  localparam logic [1:0] RegLeft = 2'd0;
  localparam logic [1:0] RegTop = 2'd1;
  localparam logic [1:0] RegRight = 2'd2;
  localparam logic [1:0] RegBottom = 2'd3;

  typedef struct packed {
    logic signed [15:0] l;
    logic signed [15:0] t;
    logic signed [15:0] r;
    logic signed [15:0] b;
  } box_t;

  // Control that travels along the row of cells with the data.
  typedef struct packed {
    logic shift;   // every cell takes the entry of its right neighbor, the last live cell the head
    logic load;    // the cell at load_idx takes the load box
    logic [IdxW-1:0] load_idx;
  } cell_ctl_t;

  function automatic logic signed [15:0] smin(logic signed [15:0] a, logic signed [15:0] b);
    return (a < b) ? a : b;
  endfunction

  function automatic logic signed [15:0] smax(logic signed [15:0] a, logic signed [15:0] b);
    return (a > b) ? a : b;
  endfunction

  function automatic box_t bound(box_t a, box_t b);
    box_t u;
    u.l = smin(a.l, b.l);
    u.t = smin(a.t, b.t);
    u.r = smax(a.r, b.r);
    u.b = smax(a.b, b.b);
    return u;
  endfunction

  function automatic logic is_empty(box_t x);
    return (x.l >= x.r) || (x.t >= x.b);
  endfunction

endpackage

### hdl/drc_cell.sv
// One storage cell of the rectangle row: holds an entry, shifts or loads it.
module drc_cell (
  input  logic              clk,
  input  drc_pkg::cell_ctl_t ctl,
  input  logic [drc_pkg::IdxW-1:0] my_idx,
  input  drc_pkg::box_t     load_box,
  input  drc_pkg::box_t     from_right,
  output drc_pkg::box_t     entry
);

  // Shift drives a rotation; a separate load writes one cell.
  always_ff @(posedge clk) begin
    if (ctl.load && ctl.load_idx == my_idx) begin
      entry <= load_box;
    end else if (ctl.shift) begin
      entry <= from_right;
    end
  end

endmodule

### hdl/drc_merge.sv
// Merge test unit: true overlap and area check, registered between the multiply and the compare.
module drc_merge (
  input  logic          clk,
  input  drc_pkg::box_t a,
  input  drc_pkg::box_t b,
  output logic          worth,
  output drc_pkg::box_t union_box
);

  drc_pkg::box_t u;
  logic ovl;
  logic signed [16:0] aw, ah, bw, bh, uw, uh;
  logic signed [33:0] pa, pb, pu;
  logic ovl_q;
  drc_pkg::box_t u_q;

  always_comb begin
    u = drc_pkg::bound(a, b);
    ovl = (drc_pkg::smax(a.l, b.l) < drc_pkg::smin(a.r, b.r)) &&
          (drc_pkg::smax(a.t, b.t) < drc_pkg::smin(a.b, b.b));
    aw = 17'(a.r) - 17'(a.l);
    ah = 17'(a.b) - 17'(a.t);
    bw = 17'(b.r) - 17'(b.l);
    bh = 17'(b.b) - 17'(b.t);
    uw = 17'(u.r) - 17'(u.l);
    uh = 17'(u.b) - 17'(u.t);
  end

  // Multiply in the first stage, compare in the second.
  always_ff @(posedge clk) begin
    pa <= 34'(aw * ah);
    pb <= 34'(bw * bh);
    pu <= 34'(uw * uh);
    ovl_q <= ovl;
    u_q <= u;
  end

  assign worth = ovl_q && (35'(pu) <= 35'(pa) + 35'(pb));
  assign union_box = u_q;

endmodule

### hdl/drc_clip.sv
// Clip unit: cuts one entry to the clip space and yields the source offsets.
module drc_clip (
  input  drc_pkg::box_t x,
  input  drc_pkg::box_t sp,
  input  logic          lim,
  output drc_pkg::box_t y,
  output logic [15:0]   dx,
  output logic [15:0]   dy
);

  drc_pkg::box_t w;
  logic dead;

  always_comb begin
    w = x;
    dx = '0;
    dy = '0;
    dead = 1'b0;
    if (lim) begin
      if (w.l < sp.l) begin
        dx = sp.l - w.l;
        w.l = sp.l;
        if (w.l > w.r) dead = 1'b1;
      end
      if (!dead && w.t < sp.t) begin
        dy = sp.t - w.t;
        w.t = sp.t;
        if (w.t > w.b) dead = 1'b1;
      end
      if (!dead && w.r > sp.r) begin
        w.r = sp.r;
        if (w.r < w.l) dead = 1'b1;
      end
      if (!dead && w.b > sp.b) begin
        w.b = sp.b;
        if (w.b < w.t) dead = 1'b1;
      end
    end
    y = dead ? '0 : w;
  end

endmodule

### hdl/dirty_rect_coalescer.sv
// Top level of the dirty rectangle coalescer: control, clip space registers and cell row.
//
// Start a command with start while busy is low; results come out one per
// cycle on the out_* ports marked by done, and last flags the final one. The
// receiver cannot stall, so every done cycle is a transfer. The list lives in
// a row of MaxEntries cells that rotate by one place on each shift, so entry 0
// always sits at the head where the merge unit and the clip unit look. An add
// walks the live list once per pass, each entry through StScan, StWait and
// StJudge (the merge test is registered between multiply and compare),
// restarting the pass after each merge; a merge at position k rotates the
// rest of the row past it.
module dirty_rect_coalescer (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  output logic        busy,
  input  logic [1:0]  action,
  input  logic signed [15:0] rect_left,
  input  logic signed [15:0] rect_top,
  input  logic signed [15:0] rect_right,
  input  logic signed [15:0] rect_bottom,
  output logic        done,
  output logic signed [15:0] out_left,
  output logic signed [15:0] out_top,
  output logic signed [15:0] out_right,
  output logic signed [15:0] out_bottom,
  output logic [15:0] src_dx,
  output logic [15:0] src_dy,
  output logic [4:0]  list_count,
  output logic        last,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [3:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  localparam int N = drc_pkg::MaxEntries;
  localparam int CW = drc_pkg::CountW;
  localparam int IW = drc_pkg::IdxW;

  localparam logic [2:0] StIdle = 3'd0;
  localparam logic [2:0] StScan = 3'd1;  // present head to merge unit
  localparam logic [2:0] StWait = 3'd2;  // merge stage 1
  localparam logic [2:0] StJudge = 3'd3; // merge result valid
  localparam logic [2:0] StRot = 3'd4;   // rotate rest of row home after a merge
  localparam logic [2:0] StEmit = 3'd5;
  localparam logic [2:0] StAnswer = 3'd6;

  logic [2:0] state;
  logic [2:0] state_next;
  logic [CW-1:0] count;
  logic [CW-1:0] pos;     // entries of this pass examined so far
  logic [CW-1:0] rot_left;
  drc_pkg::box_t cur;
  logic signed [15:0] sp_l_reg, sp_t_reg, sp_r_reg, sp_b_reg;

  drc_pkg::box_t entry [N];
  drc_pkg::box_t from_r [N];
  drc_pkg::cell_ctl_t ctl;
  drc_pkg::box_t load_box;

  drc_pkg::box_t sp;
  logic lim;
  logic worth;
  drc_pkg::box_t union_box;
  drc_pkg::box_t clip_y;
  logic [15:0] clip_dx, clip_dy;

  // Clip space, normalized on use.
  always_comb begin
    sp.l = drc_pkg::smin(sp_l_reg, sp_r_reg);
    sp.r = drc_pkg::smax(sp_l_reg, sp_r_reg);
    sp.t = drc_pkg::smin(sp_t_reg, sp_b_reg);
    sp.b = drc_pkg::smax(sp_t_reg, sp_b_reg);
    lim = !drc_pkg::is_empty(sp);
  end

  // Configuration port.
  assign pready = 1'b1;
  logic cfg_wr;
  assign cfg_wr = psel && penable && pwrite;

  always_ff @(posedge clk) begin
    if (rst) begin
      sp_l_reg <= '0;
      sp_t_reg <= '0;
      sp_r_reg <= '0;
      sp_b_reg <= '0;
    end else if (cfg_wr && paddr[1:0] == 2'b00) begin
      case (paddr[3:2])
        drc_pkg::RegLeft: sp_l_reg <= pwdata[15:0];
        drc_pkg::RegTop: sp_t_reg <= pwdata[15:0];
        drc_pkg::RegRight: sp_r_reg <= pwdata[15:0];
        drc_pkg::RegBottom: sp_b_reg <= pwdata[15:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    prdata = '0;
    case (paddr[3:2])
      drc_pkg::RegLeft: prdata = {16'b0, sp_l_reg};
      drc_pkg::RegTop: prdata = {16'b0, sp_t_reg};
      drc_pkg::RegRight: prdata = {16'b0, sp_r_reg};
      drc_pkg::RegBottom: prdata = {16'b0, sp_b_reg};
      default: prdata = '0;
    endcase
  end

  // Row of cells; the head rotates to the tail slot of the live list, so
  // the row is a ring of length count. Cell i takes cell i+1; the last live
  // cell takes the head. Cells at or above count hold junk and are never read.
  genvar g;
  generate
    for (g = 0; g < N; g++) begin : g_row
      assign from_r[g] = (IW'(g) == IW'(count - 1'b1) || g == N - 1) ?
                         entry[0] : entry[(g + 1) % N];
      drc_cell u_cell (
        .clk(clk),
        .ctl(ctl),
        .my_idx(IW'(g)),
        .load_box(load_box),
        .from_right(from_r[g]),
        .entry(entry[g])
      );
    end
  endgenerate

  drc_merge u_merge (
    .clk(clk),
    .a(entry[0]),
    .b(cur),
    .worth(worth),
    .union_box(union_box)
  );

  drc_clip u_clip (
    .x(entry[0]),
    .sp(sp),
    .lim(lim),
    .y(clip_y),
    .dx(clip_dx),
    .dy(clip_dy)
  );

  logic accept;
  logic outside;
  assign accept = start && !busy;
  assign busy = (state != StIdle);
  assign outside = lim && (rect_right < sp.l || rect_left > sp.r ||
                           rect_top > sp.b || rect_bottom < sp.t);

  // Widening of a full list's entry 0.
  drc_pkg::box_t widen;
  always_comb begin
    logic ez, ec;
    ez = drc_pkg::is_empty(entry[0]);
    ec = drc_pkg::is_empty(cur);
    if (ez && ec) widen = '0;
    else if (ez) widen = cur;
    else if (!ec) widen = drc_pkg::bound(entry[0], cur);
    else widen = entry[0];
  end

  // Sequencer. In a scan the head is tested, then the row rotates by one.
  // A merge drops the head: rotation closes over the shorter ring, so the
  // remaining entries end up back in order after rot_left more steps.
  always_comb begin
    state_next = state;
    ctl = '0;
    load_box = cur;
    case (state)
      StIdle: begin
        if (accept) begin
          if (action == drc_pkg::ActAdd) begin
            state_next = outside ? StAnswer : StScan;
          end else if (action == drc_pkg::ActEmit && count != '0) begin
            state_next = StEmit;
          end else begin
            state_next = StAnswer;
          end
        end
      end
      StScan: state_next = StWait;
      StWait: state_next = StJudge;
      StJudge: state_next = StScan;
      StRot: begin
        ctl.shift = (rot_left != '0);
        if (rot_left == '0) state_next = StScan;
      end
      StEmit: begin
        ctl.shift = 1'b1;
        if (pos == count - 1'b1) state_next = StIdle;
      end
      StAnswer: state_next = StIdle;
      default: state_next = StIdle;
    endcase
    // The scan decisions are in the sequential block; cell control for them:
    if (state == StScan && pos >= count) begin
      state_next = StAnswer;
      ctl.load = 1'b1;
      if (count >= CW'(N)) begin
        ctl.load_idx = '0;
        load_box = widen;
      end else begin
        ctl.load_idx = IW'(count);
      end
    end
    if (state == StJudge) begin
      ctl.shift = 1'b1;
      if (worth) state_next = StRot;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= StIdle;
      count <= '0;
      pos <= '0;
      rot_left <= '0;
      done <= 1'b0;
      last <= 1'b0;
    end else begin
      state <= state_next;
      done <= 1'b0;
      last <= 1'b0;
      case (state)
        StIdle: begin
          pos <= '0;
          if (accept) begin
            cur <= {rect_left, rect_top, rect_right, rect_bottom};
            if (action == drc_pkg::ActClear) count <= '0;
          end
        end
        StScan: begin
          if (pos >= count) begin
            if (count < CW'(N)) count <= count + 1'b1;
          end
        end
        StJudge: begin
          if (worth) begin
            // Head leaves the ring: the ring shrinks and rotation is skipped
            // for it; the rest travels count-1-pos more places home.
            cur <= union_box;
            count <= count - 1'b1;
            rot_left <= count - 1'b1 - pos;
            pos <= '0;
          end else begin
            pos <= pos + 1'b1;
          end
        end
        StRot: begin
          if (rot_left != '0) rot_left <= rot_left - 1'b1;
        end
        StEmit: begin
          done <= 1'b1;
          last <= (pos == count - 1'b1);
          pos <= pos + 1'b1;
        end
        StAnswer: begin
          done <= 1'b1;
          last <= 1'b1;
        end
        default: ;
      endcase
    end
  end

  // Output register: zeros except on emit.
  always_ff @(posedge clk) begin
    if (state == StEmit) begin
      {out_left, out_top, out_right, out_bottom} <= clip_y;
      src_dx <= clip_dx;
      src_dy <= clip_dy;
    end else begin
      {out_left, out_top, out_right, out_bottom} <= '0;
      src_dx <= '0;
      src_dy <= '0;
    end
  end

  assign list_count = 5'(count);

`ifndef ASSERT_OFF
  a_count_range: assert property (@(posedge clk) disable iff (rst)
    count <= CW'(N)) else $error("list count beyond capacity");
  a_done_busy: assert property (@(posedge clk) disable iff (rst)
    accept |=> !done) else $error("result in the cycle after accept");
  a_last_done: assert property (@(posedge clk) disable iff (rst)
    last |-> done) else $error("last without result");
  a_clear: assert property (@(posedge clk) disable iff (rst)
    accept && action == drc_pkg::ActClear |=> count == '0)
    else $error("clear did not empty list");
`endif

endmodule

### dv/dirty_rect_coalescer_test.sv
// Self-checking testbench for the dirty rectangle coalescer: directed table, random commands.
module dirty_rect_coalescer_test;

  timeunit 1ns;
  timeprecision 1ps;

  localparam logic [1:0] ActSpare = 2'd3;  // unused code: one result, no state change
  localparam int CycleLimit = 3000000;
  localparam int PhaseItems = 19;
  localparam int NumPhases = 5;
  localparam int DrainCycles = 40;

  logic clk = 1'b0;
  logic rst;
  logic start;
  logic busy;
  logic [1:0] action;
  logic signed [15:0] rect_left, rect_top, rect_right, rect_bottom;
  logic done;
  logic signed [15:0] out_left, out_top, out_right, out_bottom;
  logic [15:0] src_dx, src_dy;
  logic [4:0] list_count;
  logic last;
  logic psel, penable, pwrite;
  logic [3:0] paddr;
  logic [31:0] pwdata, prdata;
  logic pready;

  dirty_rect_coalescer dut (.*);

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Rectangles as the shadow list holds them: edges widened to int so that
  // differences and areas never overflow.
  typedef struct {
    int l, t, r, b;
  } rect_s;

  // One expected output transfer.
  typedef struct {
    logic [15:0] l, t, r, b, dx, dy;
    logic [4:0]  cnt;
    logic        fin;
  } emit_s;

  // One row of the directed table; exp_cnt < 0 means the predictor decides.
  typedef struct {
    logic [1:0] act;
    int l, t, r, b;
    int exp_cnt;
  } row_s;

  rect_s       shadow_list[drc_pkg::MaxEntries];
  int          shadow_cnt;
  logic [15:0] space_reg[4];
  emit_s       pending[$];
  int          errors = 0;
  int          cycles = 0;
  int          transfers = 0;
  int          accepted = 0;
  int          gap_pct = 0;

  // ---------------------------------------------------------------------
  // Shadow model of the list.
  // ---------------------------------------------------------------------
  function automatic int sext(logic [15:0] v);
    return int'($signed(v));
  endfunction

  function automatic rect_s clip_space();
    rect_s s;
    int a, c, t, d;
    a = sext(space_reg[drc_pkg::RegLeft]);
    c = sext(space_reg[drc_pkg::RegRight]);
    t = sext(space_reg[drc_pkg::RegTop]);
    d = sext(space_reg[drc_pkg::RegBottom]);
    s.l = (a < c) ? a : c;
    s.r = (a > c) ? a : c;
    s.t = (t < d) ? t : d;
    s.b = (t > d) ? t : d;
    return s;
  endfunction

  function automatic bit rect_void(rect_s x);
    return (x.l >= x.r) || (x.t >= x.b);
  endfunction

  function automatic longint rect_area(rect_s x);
    return longint'(x.r - x.l) * longint'(x.b - x.t);
  endfunction

  function automatic rect_s rect_union(rect_s a, rect_s b);
    rect_s u;
    u.l = (a.l < b.l) ? a.l : b.l;
    u.t = (a.t < b.t) ? a.t : b.t;
    u.r = (a.r > b.r) ? a.r : b.r;
    u.b = (a.b > b.b) ? a.b : b.b;
    return u;
  endfunction

  // Merge only on a true overlap whose union wastes no area.
  function automatic bit merge_pays(rect_s a, rect_s b);
    int ml, mr, mt, mb;
    ml = (a.l > b.l) ? a.l : b.l;
    mr = (a.r < b.r) ? a.r : b.r;
    mt = (a.t > b.t) ? a.t : b.t;
    mb = (a.b < b.b) ? a.b : b.b;
    if (ml >= mr || mt >= mb) return 1'b0;
    return rect_area(rect_union(a, b)) <= rect_area(a) + rect_area(b);
  endfunction

  function automatic void insert_rect(rect_s cur);
    rect_s sp, z;
    bit merged;
    sp = clip_space();
    if (!rect_void(sp) &&
        (cur.r < sp.l || cur.l > sp.r || cur.t > sp.b || cur.b < sp.t)) return;
    merged = 1'b1;
    while (merged) begin
      merged = 1'b0;
      for (int i = 0; i < shadow_cnt; i++) begin
        if (merge_pays(shadow_list[i], cur)) begin
          cur = rect_union(shadow_list[i], cur);
          for (int j = i; j < shadow_cnt - 1; j++) shadow_list[j] = shadow_list[j + 1];
          shadow_cnt--;
          merged = 1'b1;
          break;
        end
      end
    end
    if (shadow_cnt >= drc_pkg::MaxEntries) begin
      // List full: widen entry 0, ignoring empty operands.
      z = shadow_list[0];
      if (rect_void(z) && rect_void(cur)) shadow_list[0] = '{0, 0, 0, 0};
      else if (rect_void(z)) shadow_list[0] = cur;
      else if (!rect_void(cur)) shadow_list[0] = rect_union(z, cur);
    end else begin
      shadow_list[shadow_cnt] = cur;
      shadow_cnt++;
    end
  endfunction

  function automatic emit_s pack_emit(rect_s x, int dx, int dy, bit fin);
    emit_s e;
    e.l = x.l[15:0];
    e.t = x.t[15:0];
    e.r = x.r[15:0];
    e.b = x.b[15:0];
    e.dx = dx[15:0];
    e.dy = dy[15:0];
    e.cnt = shadow_cnt[4:0];
    e.fin = fin;
    return e;
  endfunction

  // Clip left, top, right, bottom in turn; a crossed edge zeroes the box but
  // keeps the offsets reached so far.
  function automatic emit_s clip_entry(rect_s x, rect_s sp, bit fin);
    int dx, dy;
    rect_s zero;
    dx = 0;
    dy = 0;
    zero = '{0, 0, 0, 0};
    if (x.l < sp.l) begin
      dx = sp.l - x.l;
      x.l = sp.l;
      if (x.l > x.r) return pack_emit(zero, dx, dy, fin);
    end
    if (x.t < sp.t) begin
      dy = sp.t - x.t;
      x.t = sp.t;
      if (x.t > x.b) return pack_emit(zero, dx, dy, fin);
    end
    if (x.r > sp.r) begin
      x.r = sp.r;
      if (x.r < x.l) return pack_emit(zero, dx, dy, fin);
    end
    if (x.b > sp.b) begin
      x.b = sp.b;
      if (x.b < x.t) return pack_emit(zero, dx, dy, fin);
    end
    return pack_emit(x, dx, dy, fin);
  endfunction

  // Advance the shadow state by one command and queue what it must produce.
  function automatic void predict_command(logic [1:0] act, logic [15:0] l, logic [15:0] t,
                                          logic [15:0] r, logic [15:0] b);
    rect_s sp;
    bit clip_on;
    if (act == drc_pkg::ActAdd) begin
      insert_rect('{sext(l), sext(t), sext(r), sext(b)});
    end else if (act == drc_pkg::ActClear) begin
      shadow_cnt = 0;
    end else if (act == drc_pkg::ActEmit && shadow_cnt > 0) begin
      sp = clip_space();
      clip_on = !rect_void(sp);
      for (int i = 0; i < shadow_cnt; i++) begin
        if (clip_on) pending.push_back(clip_entry(shadow_list[i], sp, i + 1 == shadow_cnt));
        else pending.push_back(pack_emit(shadow_list[i], 0, 0, i + 1 == shadow_cnt));
      end
      return;
    end
    pending.push_back(pack_emit('{0, 0, 0, 0}, 0, 0, 1'b1));
  endfunction

  // ---------------------------------------------------------------------
  // Drivers.
  // ---------------------------------------------------------------------
  // Present one command and hold it until it is accepted; optionally go idle after.
  task automatic issue_command(logic [1:0] act, logic [15:0] l, logic [15:0] t,
                               logic [15:0] r, logic [15:0] b, int typed_cnt);
    bit taken;
    emit_s e;
    action <= act;
    rect_left <= l;
    rect_top <= t;
    rect_right <= r;
    rect_bottom <= b;
    start <= 1'b1;
    taken = 1'b0;
    while (!taken) begin
      @(posedge clk);
      taken = !busy;
    end
    accepted++;
    predict_command(act, l, t, r, b);
    // A typed expectation replaces the predicted single result.
    if (typed_cnt >= 0) begin
      e = pending.pop_back();
      e = '{16'd0, 16'd0, 16'd0, 16'd0, 16'd0, 16'd0, typed_cnt[4:0], 1'b1};
      pending.push_back(e);
    end
    if ($urandom_range(99) < gap_pct) begin
      start <= 1'b0;
      repeat ($urandom_range(4, 1)) @(posedge clk);
    end
  endtask

  // Hold until every expected transfer is in, then let the outputs drain quietly.
  task automatic wait_quiet();
    start <= 1'b0;
    while (pending.size() != 0) @(posedge clk);
    repeat (DrainCycles) @(posedge clk);
  endtask

  // Setup cycle, access cycle; the register takes the value at the access edge.
  task automatic write_space(logic [1:0] idx, logic [15:0] val);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {idx, 2'b00};
    pwdata <= {16'd0, val};
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    space_reg[idx] = val;
  endtask

  task automatic set_space(logic [15:0] l, logic [15:0] t, logic [15:0] r, logic [15:0] b);
    write_space(drc_pkg::RegLeft, l);
    write_space(drc_pkg::RegTop, t);
    write_space(drc_pkg::RegRight, r);
    write_space(drc_pkg::RegBottom, b);
  endtask

  // Coordinates: mostly near the origin so rectangles meet and merge, now and
  // then a full 16-bit value so every bit toggles.
  function automatic int pick_coord();
    if ($urandom_range(9) == 0) return sext(16'($urandom_range(16'hFFFF, 0)));
    return int'($urandom_range(160)) - 80;
  endfunction

  task automatic random_command();
    int roll, l, t, w, h;
    logic [1:0] act;
    roll = $urandom_range(99);
    if (roll < 62) act = drc_pkg::ActAdd;
    else if (roll < 66) act = drc_pkg::ActClear;
    else if (roll < 95) act = drc_pkg::ActEmit;
    else act = ActSpare;
    l = pick_coord();
    t = pick_coord();
    // Mostly proper boxes; a few degenerate or inverted ones.
    w = ($urandom_range(9) == 0) ? -int'($urandom_range(8)) : int'($urandom_range(40, 1));
    h = ($urandom_range(9) == 0) ? -int'($urandom_range(8)) : int'($urandom_range(40, 1));
    if ($urandom_range(9) == 0) issue_command(act, l[15:0], t[15:0],
                                               16'($urandom_range(16'hFFFF, 0)),
                                               16'($urandom_range(16'hFFFF, 0)), -1);
    else issue_command(act, l[15:0], t[15:0], 16'(l + w), 16'(t + h), -1);
  endtask

  // ---------------------------------------------------------------------
  // Output checker: every done cycle is a transfer.
  // ---------------------------------------------------------------------
  always @(posedge clk) begin
    emit_s e;
    if (!rst && done) begin
      transfers++;
      if (pending.size() == 0) begin
        $display("%0t: unexpected result l=%0d t=%0d r=%0d b=%0d", $time,
                 out_left, out_top, out_right, out_bottom);
        errors++;
      end else begin
        e = pending.pop_front();
        if ({out_left, out_top, out_right, out_bottom} != {e.l, e.t, e.r, e.b}) begin
          $display("%0t: box mismatch expected %0d,%0d,%0d,%0d actual %0d,%0d,%0d,%0d",
                   $time, $signed(e.l), $signed(e.t), $signed(e.r), $signed(e.b),
                   out_left, out_top, out_right, out_bottom);
          errors++;
        end
        if (src_dx != e.dx || src_dy != e.dy) begin
          $display("%0t: offset mismatch expected dx=%0d dy=%0d actual dx=%0d dy=%0d",
                   $time, e.dx, e.dy, src_dx, src_dy);
          errors++;
        end
        if (list_count != e.cnt || last != e.fin) begin
          $display("%0t: count/last mismatch expected %0d/%0b actual %0d/%0b",
                   $time, e.cnt, e.fin, list_count, last);
          errors++;
        end
      end
    end
  end

  // Cycle budget for a run that hangs.
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CycleLimit) begin
      $display("Timeout after %0d cycles", cycles);
      $display("Simulation FAILED");
      $finish;
    end
  end

  // ---------------------------------------------------------------------
  // Stimulus.
  // ---------------------------------------------------------------------
  row_s table_rows[$];

  initial begin
    rst <= 1'b1;
    start <= 1'b0;
    action <= drc_pkg::ActAdd;
    rect_left <= '0;
    rect_top <= '0;
    rect_right <= '0;
    rect_bottom <= '0;
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    paddr <= '0;
    pwdata <= '0;
    shadow_cnt = 0;
    for (int i = 0; i < 4; i++) space_reg[i] = 16'd0;
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed rows, clip space still empty after reset.
    table_rows = '{
      '{drc_pkg::ActEmit, 0, 0, 0, 0, 0},     // empty list emits one zero result
      '{drc_pkg::ActAdd, 0, 0, 10, 10, 1},
      '{drc_pkg::ActAdd, 5, 5, 15, 15, 2},    // overlap too wasteful: append
      '{drc_pkg::ActAdd, 2, 2, 8, 8, -1},     // swallowed, then restarts the scan
      '{drc_pkg::ActAdd, 3, 3, 3, 9, -1},     // zero width never overlaps
      '{drc_pkg::ActAdd, 20, 20, 10, 10, -1}, // inverted
      '{drc_pkg::ActEmit, 0, 0, 0, 0, -1},    // unclipped report
      '{ActSpare, 1, 2, 3, 4, -1},            // unused code leaves the list alone
      // swallows every entry that has area
      '{drc_pkg::ActAdd, -32768, -32768, 32767, 32767, -1},
      '{drc_pkg::ActEmit, 0, 0, 0, 0, -1},
      '{drc_pkg::ActClear, 0, 0, 0, 0, 0},
      '{drc_pkg::ActEmit, 0, 0, 0, 0, 0}
    };
    foreach (table_rows[i])
      issue_command(table_rows[i].act, table_rows[i].l[15:0], table_rows[i].t[15:0],
                    table_rows[i].r[15:0], table_rows[i].b[15:0], table_rows[i].exp_cnt);
    // Fill past capacity with disjoint boxes to force entry-0 widening.
    for (int i = 0; i < drc_pkg::MaxEntries + 2; i++)
      issue_command(drc_pkg::ActAdd, 16'(i * 100), 16'(i * 100), 16'(i * 100 + 5),
                    16'(i * 100 + 5), -1);
    issue_command(drc_pkg::ActEmit, 0, 0, 0, 0, -1);
    wait_quiet();

    // Random phases; each sets a different clip space while idle.
    for (int p = 0; p < NumPhases; p++) begin
      case (p)
        0: begin
          gap_pct = 0;
          set_space(16'h8000, 16'h8000, 16'h7FFF, 16'h7FFF);  // widest space
        end
        1: begin
          gap_pct = 61;
          set_space(16'd40, 16'd30, 16'hFFD8, 16'hFFE2);       // swapped edges
        end
        2: begin
          gap_pct = 0;
          set_space(16'd5, 16'd0, 16'd5, 16'd50);              // zero width: no clipping
        end
        3: begin
          gap_pct = 8;
          set_space(16'hFFF0, 16'hFFF0, 16'd16, 16'd16);       // small window, collapses
        end
        default: begin
          gap_pct = 30;
          set_space(16'($urandom_range(16'hFFFF, 0)), 16'($urandom_range(16'hFFFF, 0)),
                    16'($urandom_range(16'hFFFF, 0)), 16'($urandom_range(16'hFFFF, 0)));
        end
      endcase
      for (int n = 0; n < PhaseItems; n++) random_command();
      issue_command(drc_pkg::ActEmit, 0, 0, 0, 0, -1);
      wait_quiet();
    end

    $display("Ran %0d commands over %0d clip settings, %0d result transfers checked.",
             accepted, NumPhases + 1, transfers);
    if (errors == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("%0d mismatches", errors);
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
